[rtl/rsbr_pkg.sv]
package rsbr_pkg;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  typedef enum logic [1:0] {
    LK_NONE  = 2'd0,
    LK_SRRIP = 2'd1,
    LK_BRRIP = 2'd2
  } leader_e;

  typedef struct packed {
    logic [3:0] victim_way;
    logic [1:0] inserted_position;
    logic       streaming_set;
    logic       bypassed;
  } result_t;

  typedef struct packed {
    logic       we;
    logic [4:0] addr;
    logic [1:0] data;
  } sc_wr_t;

  localparam int unsigned SIG_W       = 5;
  localparam int unsigned SIG_ENTRIES = 32;
  localparam int unsigned IN_TDATA_W  = 120;
  localparam int unsigned OUT_TDATA_W = 8;

  localparam logic [1:0] RR_MAX    = 2'd3;
  localparam logic [1:0] RR_LONG   = 2'd2;
  localparam logic [1:0] RR_NEAR   = 2'd0;
  localparam logic [1:0] SC_HOT    = 2'd2;
  localparam logic [1:0] SC_MAX    = 2'd3;
  localparam logic [1:0] SC_RESET  = 2'd1;
  localparam logic [1:0] RUN_MAX   = 2'd3;
  localparam logic [1:0] THR_RESET = 2'd2;
  localparam logic [9:0] PSEL_MID  = 10'd512;
  localparam logic [9:0] PSEL_MAX  = 10'd1023;

endpackage

[rtl/rsbr_mem.sv]
module rsbr_mem #(
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned WIDTH = 211,
  parameter int unsigned AW    = 11
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/rsbr_calc.sv]
module rsbr_calc #(
  parameter int unsigned NUM_SETS     = 2048,
  parameter int unsigned NUM_WAYS     = 16,
  parameter int unsigned LEADER_COUNT = 32,
  parameter int unsigned ADDR_BITS    = 48,
  parameter int unsigned SET_W        = $clog2(NUM_SETS),
  parameter int unsigned WAY_W        = $clog2(NUM_WAYS),
  parameter int unsigned ROW_W        = 7 * NUM_WAYS + 2 * ADDR_BITS + 3
) (
  input  logic                                         req_i,
  input  logic                                         hit_i,
  input  logic [4:0]                                   draw_i,
  input  logic [SET_W-1:0]                             set_i,
  input  logic [WAY_W-1:0]                             way_i,
  input  logic [ADDR_BITS-1:0]                         paddr_i,
  input  logic [rsbr_pkg::SIG_W-1:0]                   pc_sig_i,
  input  logic [ROW_W-1:0]                             row_i,
  input  logic [rsbr_pkg::SIG_ENTRIES-1:0][1:0]        sc_i,
  input  logic [9:0]                                   psel_i,
  input  logic [1:0]                                   thr_i,
  output logic [ROW_W-1:0]                             row_o,
  output rsbr_pkg::sc_wr_t                             sc_wr_o,
  output logic [9:0]                                   psel_o,
  output rsbr_pkg::result_t                            res_o
);
  import rsbr_pkg::*;

  localparam int unsigned SIG_OFF = 2 * NUM_WAYS;
  localparam int unsigned ADR_OFF = 7 * NUM_WAYS;
  localparam int unsigned STR_OFF = ADR_OFF + ADDR_BITS;
  localparam int unsigned RUN_OFF = STR_OFF + ADDR_BITS + 1;
  localparam int unsigned SPACING = NUM_SETS / LEADER_COUNT;

  logic [1:0]           rr      [NUM_WAYS];
  logic [1:0]           mx;
  logic [WAY_W-1:0]     victim;
  logic                 found;
  logic [ADDR_BITS-1:0] last;
  logic [ADDR_BITS:0]   stride;
  logic [ADDR_BITS:0]   prev_stride;
  logic [1:0]           run_old;
  logic [1:0]           run_new;
  logic [SIG_W-1:0]     sig;
  logic [SIG_W-1:0]     bs;
  logic [1:0]           bs_dec;
  logic [1:0]           cs;
  leader_e              kind;
  logic                 brrip;
  logic                 streaming;
  logic [1:0]           ins;
  logic                 bypass;

  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      rr[w] = row_i[2*w +: 2];
    end
    mx = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (rr[w] > mx) mx = rr[w];
    end
    victim = '0;
    found  = 1'b0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (!found && rr[w] == mx) begin
        victim = WAY_W'(w);
        found  = 1'b1;
      end
    end

    last        = row_i[ADR_OFF +: ADDR_BITS];
    prev_stride = row_i[STR_OFF +: ADDR_BITS+1];
    run_old     = row_i[RUN_OFF +: 2];
    stride      = (last == '0) ? '0 : ({1'b0, paddr_i} - {1'b0, last});
    if (last != '0 && stride == prev_stride && stride != '0) begin
      run_new = (run_old < RUN_MAX) ? run_old + 2'd1 : run_old;
    end else begin
      run_new = (run_old > 2'd0) ? run_old - 2'd1 : run_old;
    end

    sig    = pc_sig_i ^ set_i[SIG_W-1:0];
    bs     = row_i[SIG_OFF + SIG_W*way_i +: SIG_W];
    bs_dec = (sc_i[bs] > 2'd0) ? sc_i[bs] - 2'd1 : sc_i[bs];
    cs     = (sig == bs) ? bs_dec : sc_i[sig];

    kind = LK_NONE;
    for (int i = 0; i < LEADER_COUNT; i++) begin
      if (set_i == SET_W'(SPACING * i)) begin
        kind = (i < LEADER_COUNT / 2) ? LK_SRRIP : LK_BRRIP;
      end
    end
    unique case (kind)
      LK_SRRIP: brrip = 1'b0;
      LK_BRRIP: brrip = 1'b1;
      default:  brrip = (psel_i >= PSEL_MID);
    endcase
    streaming = (run_new >= thr_i);
    ins    = (brrip && draw_i != 5'd0) ? RR_MAX : RR_LONG;
    bypass = 1'b0;
    if (cs >= SC_HOT) ins = RR_NEAR;
    if (streaming && cs < SC_HOT) begin
      ins    = RR_MAX;
      bypass = 1'b1;
    end

    row_o   = row_i;
    sc_wr_o = '0;
    psel_o  = psel_i;
    res_o   = '0;
    if (!req_i) begin
      for (int w = 0; w < NUM_WAYS; w++) begin
        row_o[2*w +: 2] = rr[w] + (RR_MAX - mx);
      end
      res_o.victim_way        = 4'(victim);
      res_o.inserted_position = RR_MAX;
      res_o.streaming_set     = (run_old >= thr_i);
    end else begin
      row_o[ADR_OFF +: ADDR_BITS]   = paddr_i;
      row_o[STR_OFF +: ADDR_BITS+1] = stride;
      row_o[RUN_OFF +: 2]           = run_new;
      res_o.streaming_set           = streaming;
      sc_wr_o.we   = 1'b1;
      sc_wr_o.addr = bs;
      if (hit_i) begin
        row_o[2*way_i +: 2]     = RR_NEAR;
        sc_wr_o.data            = (sc_i[bs] < SC_MAX) ? sc_i[bs] + 2'd1 : sc_i[bs];
        res_o.inserted_position = RR_NEAR;
      end else begin
        row_o[2*way_i +: 2]                 = ins;
        row_o[SIG_OFF + SIG_W*way_i +: SIG_W] = sig;
        sc_wr_o.data            = bs_dec;
        res_o.inserted_position = ins;
        res_o.bypassed          = bypass;
        unique case (kind)
          LK_SRRIP: psel_o = (psel_i < PSEL_MAX) ? psel_i + 10'd1 : psel_i;
          LK_BRRIP: psel_o = (psel_i > 10'd0) ? psel_i - 10'd1 : psel_i;
          default:  psel_o = psel_i;
        endcase
      end
    end
  end

endmodule

[rtl/rrip_ship_stream_bypass_replacer.sv]
// Cache replacement engine: RRIP ageing, set dueling, signature hit predictor
// and a per-set stride detector that pushes cold blocks in streaming sets out.
// Slave stream carries one request per item (tuser = request type); the
// master stream returns exactly one result item per request.
// Each item is handled in two steps: the set's row is read from the set memory,
// then computed and written back; the next item is taken only after that
// write-back. The row memory has one read port and one write port.
// m_axis_tvalid rises once the result is committed to the output register, when it is free.
// The result sits in an output register; while it waits, the next item is
// still read from memory and held until the register is free.
// After reset a clearing pass writes every set row with s_axis_tready low;
// the threshold register may be written meanwhile.
// cfg_we_i/cfg_wdata_i write the streaming threshold (reset 2); the user writes it while idle, not enforced.
module rrip_ship_stream_bypass_replacer #(
  parameter int unsigned NUM_SETS     = 2048,
  parameter int unsigned NUM_WAYS     = 16,
  parameter int unsigned LEADER_COUNT = 32,
  parameter int unsigned ADDR_BITS    = 48
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // set_index, way_index, phys_addr, prog_counter, was_hit, random_draw
  input  logic [rsbr_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // req_type
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // victim_way, inserted_position, streaming_set, bypassed
  output logic [rsbr_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input  logic                               cfg_we_i,
  input  logic [1:0]                         cfg_wdata_i
);
  import rsbr_pkg::*;

  localparam int unsigned SET_W = $clog2(NUM_SETS);
  localparam int unsigned WAY_W = $clog2(NUM_WAYS);
  localparam int unsigned PA_W  = (ADDR_BITS < 48) ? ADDR_BITS : 48;
  localparam int unsigned ROW_W = 7 * NUM_WAYS + 2 * ADDR_BITS + 3;

  state_e                           state_q, state_d;
  logic                             clr_q;
  logic [SET_W-1:0]                 clr_cnt_q;
  logic [1:0]                       thr_q;
  logic [9:0]                       psel_q;
  logic [9:0]                       psel_d;
  logic [SIG_ENTRIES-1:0][1:0]      sc_q;
  logic                             req_q, hit_q;
  logic [4:0]                       draw_q;
  logic [SET_W-1:0]                 set_q;
  logic [WAY_W-1:0]                 way_q;
  logic [ADDR_BITS-1:0]             paddr_q;
  logic [SIG_W-1:0]                 pc_sig_q;
  logic                             out_v_q;
  result_t                          out_q;
  logic                             accept, commit;
  logic [SET_W-1:0]                 in_set;
  logic [ROW_W-1:0]                 rdata, row_new, clr_row, wdata;
  logic [SET_W-1:0]                 waddr;
  sc_wr_t                           sc_wr;
  result_t                          res;

  assign in_set        = SET_W'(s_axis_tdata[10:0]);
  assign s_axis_tready = (state_q == ST_IDLE) && !clr_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign commit        = (state_q == ST_RUN) && (!out_v_q || m_axis_tready);

  always_comb begin
    clr_row = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      clr_row[2*w +: 2] = RR_LONG;
    end
  end

  assign wdata = clr_q ? clr_row : row_new;
  assign waddr = clr_q ? clr_cnt_q : set_q;

  rsbr_mem #(.DEPTH(NUM_SETS), .WIDTH(ROW_W), .AW(SET_W)) u_mem (
    .clk_i   (clk_i),
    .we_i    (clr_q || commit),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (accept),
    .raddr_i (in_set),
    .rdata_o (rdata)
  );

  rsbr_calc #(
    .NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS),
    .LEADER_COUNT(LEADER_COUNT), .ADDR_BITS(ADDR_BITS)
  ) u_calc (
    .req_i    (req_q),
    .hit_i    (hit_q),
    .draw_i   (draw_q),
    .set_i    (set_q),
    .way_i    (way_q),
    .paddr_i  (paddr_q),
    .pc_sig_i (pc_sig_q),
    .row_i    (rdata),
    .sc_i     (sc_q),
    .psel_i   (psel_q),
    .thr_i    (thr_q),
    .row_o    (row_new),
    .sc_wr_o  (sc_wr),
    .psel_o   (psel_d),
    .res_o    (res)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_RUN;
      ST_RUN:  if (commit) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
      thr_q     <= THR_RESET;
      psel_q    <= PSEL_MID;
      out_v_q   <= 1'b0;
      for (int i = 0; i < SIG_ENTRIES; i++) begin
        sc_q[i] <= SC_RESET;
      end
    end else begin
      state_q <= state_d;
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == SET_W'(NUM_SETS - 1)) clr_q <= 1'b0;
      end
      if (cfg_we_i) thr_q <= cfg_wdata_i;
      if (commit) begin
        psel_q  <= psel_d;
        out_v_q <= 1'b1;
        if (sc_wr.we) sc_q[sc_wr.addr] <= sc_wr.data;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q    <= s_axis_tuser;
      set_q    <= in_set;
      way_q    <= WAY_W'(s_axis_tdata[14:11]);
      paddr_q  <= ADDR_BITS'(s_axis_tdata[15 +: PA_W]);
      pc_sig_q <= s_axis_tdata[69:65];
      hit_q    <= s_axis_tdata[111];
      draw_q   <= s_axis_tdata[116:112];
    end
    if (commit) out_q <= res;
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {out_q.bypassed, out_q.streaming_set,
                          out_q.inserted_position, out_q.victim_way};

  a_accept_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_RUN) else $error("accepted item not processed");
  a_commit_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> m_axis_tvalid) else $error("result lost");
  a_no_accept_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !s_axis_tready) else $error("item taken during clearing pass");
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule
